FILE: hw/rtl/nrpe_pkg.sv
// ----------------------------------------------------------------------------
// nrpe_pkg
// Types and constants shared by the RMC position extractor modules.
// ----------------------------------------------------------------------------
package nrpe_pkg;

   // configuration register
   localparam int HOUR_W = 5;
   typedef logic [HOUR_W-1:0] hour_type;
   localparam hour_type HOUR_OFFSET_RESET = 5'd2;

   // characters of the sentence
   typedef logic [7:0] char_type;
   localparam char_type CHAR_DOLLAR = 8'h24;
   localparam char_type CHAR_G      = 8'h47;
   localparam char_type CHAR_N      = 8'h4E;
   localparam char_type CHAR_R      = 8'h52;
   localparam char_type CHAR_M      = 8'h4D;
   localparam char_type CHAR_C      = 8'h43;
   localparam char_type CHAR_S      = 8'h53;
   localparam char_type CHAR_W      = 8'h57;
   localparam char_type CHAR_COMMA  = 8'h2C;
   localparam char_type CHAR_STAR   = 8'h2A;
   localparam char_type CHAR_DOT    = 8'h2E;
   localparam char_type CHAR_LF     = 8'h0A;
   localparam char_type CHAR_ZERO   = 8'h30;
   localparam char_type CHAR_NINE   = 8'h39;

   // field numbers, counted by commas
   typedef logic [3:0] field_type;
   localparam field_type FIELD_NONE = 4'd0;
   localparam field_type FIELD_TIME = 4'd1;
   localparam field_type FIELD_LAT  = 4'd3;
   localparam field_type FIELD_NS   = 4'd4;
   localparam field_type FIELD_LON  = 4'd5;
   localparam field_type FIELD_EW   = 4'd6;
   localparam field_type FIELD_DATE = 4'd9;
   localparam field_type FIELD_LAST = 4'd15;

   // header matcher
   typedef enum logic [2:0] {
      HDR_IDLE,
      HDR_DOLLAR,
      HDR_G,
      HDR_N,
      HDR_R,
      HDR_M,
      HDR_C
   } hdr_state_type;

   // accumulator widths and limits
   localparam int TIME_BCD_W = 24;
   localparam int TIME_DIGITS = 6;
   localparam int DATE_ACC_W = 20;
   localparam int LAT_INT_W = 14;
   localparam int LON_INT_W = 15;
   localparam logic [LAT_INT_W-1:0] LAT_INT_CAP = 14'd16383;
   localparam logic [LON_INT_W-1:0] LON_INT_CAP = 15'd32767;

   // divide by 100 through a reciprocal
   localparam int DIV_BASE = 100;
   localparam int LAT_DIV_SHIFT = LAT_INT_W + $clog2(DIV_BASE);
   localparam int LAT_DIV_MUL = (2**LAT_DIV_SHIFT + DIV_BASE - 1) / DIV_BASE;
   localparam int LAT_MUL_W = $clog2(LAT_DIV_MUL + 1);
   localparam int LAT_Q_W = 8;
   localparam int LON_DIV_SHIFT = LON_INT_W + $clog2(DIV_BASE);
   localparam int LON_DIV_MUL = (2**LON_DIV_SHIFT + DIV_BASE - 1) / DIV_BASE;
   localparam int LON_MUL_W = $clog2(LON_DIV_MUL + 1);
   localparam int LON_Q_W = 9;

   // output limits
   localparam logic [6:0]  LAT_DEG_CAP   = 7'd90;
   localparam logic [7:0]  LON_DEG_CAP   = 8'd180;
   localparam logic [5:0]  MINSEC_CAP    = 6'd59;
   localparam logic [9:0]  DECISEC_CAP   = 10'd599;
   localparam logic [18:0] DATE_CAP      = 19'd311299;
   localparam logic [7:0]  HOURS_PER_DAY = 8'd24;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  local_hour;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
      logic [6:0]  lat_degrees;
      logic [5:0]  lat_minutes;
      logic [9:0]  lat_decisec;
      logic        lat_south;
      logic [7:0]  lon_degrees;
      logic [5:0]  lon_minutes;
      logic [9:0]  lon_decisec;
      logic        lon_west;
      logic [18:0] date_ddmmyy;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/nrpe_stream_if.sv
// ----------------------------------------------------------------------------
// nrpe_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface nrpe_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/nrpe_parser.sv
// ----------------------------------------------------------------------------
// nrpe_parser
// Byte-wise sentence parser: header match, field split and digit accumulation.
// ----------------------------------------------------------------------------
module nrpe_parser #(
   parameter int FRAC_DIGITS = 4,
   localparam int FRAC_W = $clog2(10**FRAC_DIGITS),
   localparam int FDIG_W = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  nrpe_pkg::char_type                    rx_byte,
   output logic                                  emit,
   output logic [nrpe_pkg::TIME_BCD_W-1:0]       time_bcd,
   output logic [nrpe_pkg::LAT_INT_W-1:0]        lat_int,
   output logic [FRAC_W-1:0]                     lat_frac,
   output logic [FDIG_W-1:0]                     lat_fdig,
   output logic [nrpe_pkg::LON_INT_W-1:0]        lon_int,
   output logic [FRAC_W-1:0]                     lon_frac,
   output logic [FDIG_W-1:0]                     lon_fdig,
   output logic [1:0]                            hemi,
   output logic [nrpe_pkg::DATE_ACC_W-1:0]       date_acc
);
   import nrpe_pkg::*;

   hdr_state_type          hdr_ff, hdr_in;
   logic                   in_sent_ff, in_sent_in;
   field_type              field_ff, field_in;
   logic [3:0]             dpos_ff, dpos_in;
   logic [TIME_BCD_W-1:0]  time_ff, time_in;
   logic [LAT_INT_W-1:0]   lat_int_ff, lat_int_in;
   logic [FRAC_W-1:0]      lat_frac_ff, lat_frac_in;
   logic [FDIG_W-1:0]      lat_fdig_ff, lat_fdig_in;
   logic [LON_INT_W-1:0]   lon_int_ff, lon_int_in;
   logic [FRAC_W-1:0]      lon_frac_ff, lon_frac_in;
   logic [FDIG_W-1:0]      lon_fdig_ff, lon_fdig_in;
   logic [1:0]             hemi_ff, hemi_in;
   logic [DATE_ACC_W-1:0]  date_ff, date_in;

   logic                   is_digit;
   logic [3:0]             digit;
   logic [2:0]             dcount;
   logic                   in_frac;
   logic [FRAC_W+3:0]      lat_frac_next;
   logic [FRAC_W+3:0]      lon_frac_next;
   logic [DATE_ACC_W+3:0]  date_next;

   function automatic logic [LAT_INT_W-1:0] lat_sat_add(
      input logic [LAT_INT_W-1:0] acc,
      input logic [3:0]           d
   );
      logic [LAT_INT_W+3:0] v;
      v = (LAT_INT_W+4)'(acc) * (LAT_INT_W+4)'(10) + (LAT_INT_W+4)'(d);
      return (v > (LAT_INT_W+4)'(LAT_INT_CAP)) ? LAT_INT_CAP : v[LAT_INT_W-1:0];
   endfunction

   function automatic logic [LON_INT_W-1:0] lon_sat_add(
      input logic [LON_INT_W-1:0] acc,
      input logic [3:0]           d
   );
      logic [LON_INT_W+3:0] v;
      v = (LON_INT_W+4)'(acc) * (LON_INT_W+4)'(10) + (LON_INT_W+4)'(d);
      return (v > (LON_INT_W+4)'(LON_INT_CAP)) ? LON_INT_CAP : v[LON_INT_W-1:0];
   endfunction

   assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign digit    = rx_byte[3:0];
   assign dcount   = dpos_ff[2:0];
   assign in_frac  = dpos_ff[3];

   assign lat_frac_next = (FRAC_W+4)'(lat_frac_ff) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
   assign lon_frac_next = (FRAC_W+4)'(lon_frac_ff) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
   assign date_next = (DATE_ACC_W+4)'(date_ff) * (DATE_ACC_W+4)'(10)
                    + (DATE_ACC_W+4)'(digit);

   assign emit = accept && in_sent_ff && (rx_byte == CHAR_LF);

   always_comb begin
      hdr_in      = hdr_ff;
      in_sent_in  = in_sent_ff;
      field_in    = field_ff;
      dpos_in     = dpos_ff;
      time_in     = time_ff;
      lat_int_in  = lat_int_ff;
      lat_frac_in = lat_frac_ff;
      lat_fdig_in = lat_fdig_ff;
      lon_int_in  = lon_int_ff;
      lon_frac_in = lon_frac_ff;
      lon_fdig_in = lon_fdig_ff;
      hemi_in     = hemi_ff;
      date_in     = date_ff;
      if (accept) begin
         if ((rx_byte == CHAR_DOLLAR) || (in_sent_ff && (rx_byte == CHAR_LF))) begin
            // start of a new sentence or end of a recognized one
            hdr_in      = (rx_byte == CHAR_DOLLAR) ? HDR_DOLLAR : HDR_IDLE;
            in_sent_in  = 1'b0;
            field_in    = FIELD_NONE;
            dpos_in     = '0;
            time_in     = '0;
            lat_int_in  = '0;
            lat_frac_in = '0;
            lat_fdig_in = '0;
            lon_int_in  = '0;
            lon_frac_in = '0;
            lon_fdig_in = '0;
            hemi_in     = '0;
            date_in     = '0;
         end else if (in_sent_ff) begin
            if (rx_byte == CHAR_COMMA) begin
               dpos_in = '0;
               if (field_ff != FIELD_LAST) begin
                  field_in = field_ff + 4'd1;
               end
            end else if (rx_byte == CHAR_STAR) begin
               dpos_in  = '0;
               field_in = FIELD_LAST;
            end else if (rx_byte == CHAR_DOT) begin
               if (!in_frac) begin
                  dpos_in = 4'b1000;
               end
            end else begin
               case (field_ff)
                  FIELD_TIME: begin
                     if (is_digit && !in_frac && (dcount < 3'(TIME_DIGITS))) begin
                        time_in = {time_ff[TIME_BCD_W-5:0], digit};
                        dpos_in = dpos_ff + 4'd1;
                     end
                  end
                  FIELD_LAT: begin
                     if (is_digit) begin
                        if (in_frac) begin
                           if (dcount < 3'(FRAC_DIGITS)) begin
                              lat_frac_in = lat_frac_next[FRAC_W-1:0];
                              lat_fdig_in = lat_fdig_ff + FDIG_W'(1);
                              dpos_in     = dpos_ff + 4'd1;
                           end
                        end else begin
                           lat_int_in = lat_sat_add(lat_int_ff, digit);
                           if (dcount != 3'd7) begin
                              dpos_in = dpos_ff + 4'd1;
                           end
                        end
                     end
                  end
                  FIELD_NS: begin
                     hemi_in[0] = (rx_byte == CHAR_S);
                  end
                  FIELD_LON: begin
                     if (is_digit) begin
                        if (in_frac) begin
                           if (dcount < 3'(FRAC_DIGITS)) begin
                              lon_frac_in = lon_frac_next[FRAC_W-1:0];
                              lon_fdig_in = lon_fdig_ff + FDIG_W'(1);
                              dpos_in     = dpos_ff + 4'd1;
                           end
                        end else begin
                           lon_int_in = lon_sat_add(lon_int_ff, digit);
                           if (dcount != 3'd7) begin
                              dpos_in = dpos_ff + 4'd1;
                           end
                        end
                     end
                  end
                  FIELD_EW: begin
                     hemi_in[1] = (rx_byte == CHAR_W);
                  end
                  FIELD_DATE: begin
                     if (is_digit && !in_frac && (dcount < 3'(TIME_DIGITS))) begin
                        date_in = date_next[DATE_ACC_W-1:0];
                        dpos_in = dpos_ff + 4'd1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else begin
            hdr_in = HDR_IDLE;
            case (hdr_ff)
               HDR_DOLLAR: begin
                  if (rx_byte == CHAR_G) begin
                     hdr_in = HDR_G;
                  end
               end
               HDR_G: begin
                  if (rx_byte == CHAR_N) begin
                     hdr_in = HDR_N;
                  end
               end
               HDR_N: begin
                  if (rx_byte == CHAR_R) begin
                     hdr_in = HDR_R;
                  end
               end
               HDR_R: begin
                  if (rx_byte == CHAR_M) begin
                     hdr_in = HDR_M;
                  end
               end
               HDR_M: begin
                  if (rx_byte == CHAR_C) begin
                     hdr_in = HDR_C;
                  end
               end
               HDR_C: begin
                  if (rx_byte == CHAR_COMMA) begin
                     in_sent_in = 1'b1;
                     field_in   = FIELD_TIME;
                     dpos_in    = '0;
                  end
               end
               default: begin
                  hdr_in = HDR_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff     <= HDR_IDLE;
         in_sent_ff <= 1'b0;
         field_ff   <= FIELD_NONE;
         dpos_ff    <= '0;
      end else begin
         hdr_ff     <= hdr_in;
         in_sent_ff <= in_sent_in;
         field_ff   <= field_in;
         dpos_ff    <= dpos_in;
      end
   end

   // cleared by every dollar sign before a sentence can use them
   always_ff @(posedge clock) begin
      time_ff     <= time_in;
      lat_int_ff  <= lat_int_in;
      lat_frac_ff <= lat_frac_in;
      lat_fdig_ff <= lat_fdig_in;
      lon_int_ff  <= lon_int_in;
      lon_frac_ff <= lon_frac_in;
      lon_fdig_ff <= lon_fdig_in;
      hemi_ff     <= hemi_in;
      date_ff     <= date_in;
   end

   assign time_bcd = time_ff;
   assign lat_int  = lat_int_ff;
   assign lat_frac = lat_frac_ff;
   assign lat_fdig = lat_fdig_ff;
   assign lon_int  = lon_int_ff;
   assign lon_frac = lon_frac_ff;
   assign lon_fdig = lon_fdig_ff;
   assign hemi     = hemi_ff;
   assign date_acc = date_ff;

endmodule

FILE: hw/rtl/nrpe_format.sv
// ----------------------------------------------------------------------------
// nrpe_format
// Two-stage conversion of the parsed fields into the result transaction.
// ----------------------------------------------------------------------------
module nrpe_format #(
   parameter int FRAC_DIGITS = 4,
   localparam int FRAC_W = $clog2(10**FRAC_DIGITS),
   localparam int FDIG_W = $clog2(FRAC_DIGITS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  load,
   input  nrpe_pkg::hour_type                    hour_offset,
   input  logic [nrpe_pkg::TIME_BCD_W-1:0]       time_bcd,
   input  logic [nrpe_pkg::LAT_INT_W-1:0]        lat_int,
   input  logic [FRAC_W-1:0]                     lat_frac,
   input  logic [FDIG_W-1:0]                     lat_fdig,
   input  logic [nrpe_pkg::LON_INT_W-1:0]        lon_int,
   input  logic [FRAC_W-1:0]                     lon_frac,
   input  logic [FDIG_W-1:0]                     lon_fdig,
   input  logic [1:0]                            hemi,
   input  logic [nrpe_pkg::DATE_ACC_W-1:0]       date_acc,
   output logic                                  rsp_valid,
   output nrpe_pkg::rsp_payload_type             rsp_data
);
   import nrpe_pkg::*;

   // decisec = frac * 600 / 10^k for k fraction digits, via reciprocal
   localparam logic [63:0] TOP_POW = 64'd10 ** FRAC_DIGITS;
   localparam int TOP_SHIFT = 2 * $clog2(TOP_POW);
   localparam logic [63:0] TOP_MUL = ((64'd600 << TOP_SHIFT) + TOP_POW - 64'd1) / TOP_POW;
   localparam int MUL_W = $clog2(TOP_MUL + 64'd1);
   localparam int PROD_W = FRAC_W + MUL_W;
   localparam int SH_W = $clog2(TOP_SHIFT + 1);
   localparam int TAB_N = 2**FDIG_W;

   logic [MUL_W-1:0] mul_tab [TAB_N];
   logic [SH_W-1:0]  sh_tab [TAB_N];

   for (genvar k = 0; k < TAB_N; k++) begin : g_tab
      if (k <= FRAC_DIGITS) begin : g_used
         localparam logic [63:0] DEC_POW = 64'd10 ** k;
         localparam int SHIFT = 2 * $clog2(DEC_POW);
         localparam logic [63:0] RECIP = ((64'd600 << SHIFT) + DEC_POW - 64'd1) / DEC_POW;
         assign mul_tab[k] = MUL_W'(RECIP);
         assign sh_tab[k]  = SH_W'(SHIFT);
      end else begin : g_unused
         assign mul_tab[k] = '0;
         assign sh_tab[k]  = '0;
      end
   end

   function automatic logic [4:0] hour_wrap(input logic [7:0] sum);
      logic [7:0] v;
      v = sum;
      for (int i = 0; i < 5; i++) begin
         if (v >= HOURS_PER_DAY) begin
            v = v - HOURS_PER_DAY;
         end
      end
      return v[4:0];
   endfunction

   function automatic logic [5:0] sat_minsec(input logic [6:0] v);
      return (v > 7'(MINSEC_CAP)) ? MINSEC_CAP : v[5:0];
   endfunction

   // first stage
   logic                          f1_vld_ff, f1_vld_in;
   logic [7:0]                    hr_sum_ff, hr_sum_in;
   logic [5:0]                    minute_ff, minute_in;
   logic [5:0]                    second_ff, second_in;
   logic [LAT_INT_W-1:0]          lat_x_ff;
   logic [LAT_Q_W-1:0]            lat_q_ff, lat_q_in;
   logic [LON_INT_W-1:0]          lon_x_ff;
   logic [LON_Q_W-1:0]            lon_q_ff, lon_q_in;
   logic [PROD_W-1:0]             lat_prod_ff, lat_prod_in;
   logic [PROD_W-1:0]             lon_prod_ff, lon_prod_in;
   logic [FDIG_W-1:0]             lat_fdig_ff;
   logic [FDIG_W-1:0]             lon_fdig_ff;
   logic [1:0]                    hemi_ff;
   logic [18:0]                   date_ff, date_in;

   logic [6:0]                    hr_bin;
   logic [6:0]                    min_bin;
   logic [6:0]                    sec_bin;
   logic [LAT_INT_W+LAT_MUL_W-1:0] lat_div_prod;
   logic [LON_INT_W+LON_MUL_W-1:0] lon_div_prod;

   // result register
   logic                          out_vld_ff, out_vld_in;
   rsp_payload_type               out_ff, out_in;

   logic [LAT_INT_W-1:0]          lat_rem;
   logic [LON_INT_W-1:0]          lon_rem;
   logic [PROD_W-1:0]             lat_shift;
   logic [PROD_W-1:0]             lon_shift;

   always_comb begin
      hr_bin  = 7'(time_bcd[23:20]) * 7'd10 + 7'(time_bcd[19:16]);
      min_bin = 7'(time_bcd[15:12]) * 7'd10 + 7'(time_bcd[11:8]);
      sec_bin = 7'(time_bcd[7:4]) * 7'd10 + 7'(time_bcd[3:0]);
      hr_sum_in = 8'(hr_bin) + 8'(hour_offset);
      minute_in = sat_minsec(min_bin);
      second_in = sat_minsec(sec_bin);

      lat_div_prod = (LAT_INT_W+LAT_MUL_W)'(lat_int)
                   * (LAT_INT_W+LAT_MUL_W)'(LAT_DIV_MUL);
      lon_div_prod = (LON_INT_W+LON_MUL_W)'(lon_int)
                   * (LON_INT_W+LON_MUL_W)'(LON_DIV_MUL);
      lat_q_in = lat_div_prod[LAT_DIV_SHIFT +: LAT_Q_W];
      lon_q_in = lon_div_prod[LON_DIV_SHIFT +: LON_Q_W];

      lat_prod_in = PROD_W'(lat_frac) * PROD_W'(mul_tab[lat_fdig]);
      lon_prod_in = PROD_W'(lon_frac) * PROD_W'(mul_tab[lon_fdig]);

      date_in = (date_acc > DATE_ACC_W'(DATE_CAP)) ? DATE_CAP : date_acc[18:0];

      f1_vld_in = advance ? load : f1_vld_ff;
   end

   always_comb begin
      lat_rem   = lat_x_ff - LAT_INT_W'(lat_q_ff) * LAT_INT_W'(DIV_BASE);
      lon_rem   = lon_x_ff - LON_INT_W'(lon_q_ff) * LON_INT_W'(DIV_BASE);
      lat_shift = lat_prod_ff >> sh_tab[lat_fdig_ff];
      lon_shift = lon_prod_ff >> sh_tab[lon_fdig_ff];

      out_in.local_hour       = hour_wrap(hr_sum_ff);
      out_in.minute_of_hour   = minute_ff;
      out_in.second_of_minute = second_ff;
      out_in.lat_degrees      = (lat_q_ff > LAT_Q_W'(LAT_DEG_CAP)) ?
                                LAT_DEG_CAP : lat_q_ff[6:0];
      out_in.lat_minutes      = (lat_rem > LAT_INT_W'(MINSEC_CAP)) ?
                                MINSEC_CAP : lat_rem[5:0];
      out_in.lat_decisec      = (lat_shift > PROD_W'(DECISEC_CAP)) ?
                                DECISEC_CAP : lat_shift[9:0];
      out_in.lat_south        = hemi_ff[0];
      out_in.lon_degrees      = (lon_q_ff > LON_Q_W'(LON_DEG_CAP)) ?
                                LON_DEG_CAP : lon_q_ff[7:0];
      out_in.lon_minutes      = (lon_rem > LON_INT_W'(MINSEC_CAP)) ?
                                MINSEC_CAP : lon_rem[5:0];
      out_in.lon_decisec      = (lon_shift > PROD_W'(DECISEC_CAP)) ?
                                DECISEC_CAP : lon_shift[9:0];
      out_in.lon_west         = hemi_ff[1];
      out_in.date_ddmmyy      = date_ff;

      out_vld_in = advance ? f1_vld_ff : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff  <= f1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hr_sum_ff   <= hr_sum_in;
         minute_ff   <= minute_in;
         second_ff   <= second_in;
         lat_x_ff    <= lat_int;
         lat_q_ff    <= lat_q_in;
         lon_x_ff    <= lon_int;
         lon_q_ff    <= lon_q_in;
         lat_prod_ff <= lat_prod_in;
         lon_prod_ff <= lon_prod_in;
         lat_fdig_ff <= lat_fdig;
         lon_fdig_ff <= lon_fdig;
         hemi_ff     <= hemi;
         date_ff     <= date_in;
         out_ff      <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: hw/rtl/nmea_rmc_position_extractor.sv
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor
// Parses RMC sentences from a byte stream and reports time, position, date.
// ----------------------------------------------------------------------------
//   channel      direction  payload                           handshake
//   req_channel  in         rx_byte, one character            valid/ready
//   rsp_channel  out        local time, lat, lon, date        valid/ready
//   csr_*        in         hour_offset (reset 2)             write enable
//
// one byte accepted per cycle while the result side keeps up
// a result passes the conversion stage and the result register after
// its line feed is accepted
// reset is synchronous; no clearing pass
// a stalled result holds the whole pipeline and drops req ready
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor #(
   parameter int FRAC_DIGITS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  nrpe_pkg::hour_type  csr_wr_data,
   nrpe_stream_if.sink         req_channel,
   nrpe_stream_if.source       rsp_channel
);
   import nrpe_pkg::*;

   localparam int FRAC_W = $clog2(10**FRAC_DIGITS);
   localparam int FDIG_W = $clog2(FRAC_DIGITS + 1);

   hour_type               hour_offset_ff, hour_offset_in;
   logic                   advance;
   logic                   accept;
   logic                   emit;
   logic [TIME_BCD_W-1:0]  time_bcd;
   logic [LAT_INT_W-1:0]   lat_int;
   logic [FRAC_W-1:0]      lat_frac;
   logic [FDIG_W-1:0]      lat_fdig;
   logic [LON_INT_W-1:0]   lon_int;
   logic [FRAC_W-1:0]      lon_frac;
   logic [FDIG_W-1:0]      lon_fdig;
   logic [1:0]             hemi;
   logic [DATE_ACC_W-1:0]  date_acc;
   logic                   rsp_valid;
   rsp_payload_type        rsp_data;

   assign advance = !rsp_valid || rsp_channel.ready;
   assign accept  = req_channel.valid && advance;
   assign req_channel.ready = advance;

   assign hour_offset_in = csr_wr_en ? csr_wr_data : hour_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_offset_ff <= HOUR_OFFSET_RESET;
      end else begin
         hour_offset_ff <= hour_offset_in;
      end
   end

   nrpe_parser #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .rx_byte  (req_channel.data.rx_byte),
      .emit     (emit),
      .time_bcd (time_bcd),
      .lat_int  (lat_int),
      .lat_frac (lat_frac),
      .lat_fdig (lat_fdig),
      .lon_int  (lon_int),
      .lon_frac (lon_frac),
      .lon_fdig (lon_fdig),
      .hemi     (hemi),
      .date_acc (date_acc)
   );

   nrpe_format #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_format (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .load        (emit),
      .hour_offset (hour_offset_ff),
      .time_bcd    (time_bcd),
      .lat_int     (lat_int),
      .lat_frac    (lat_frac),
      .lat_fdig    (lat_fdig),
      .lon_int     (lon_int),
      .lon_frac    (lon_frac),
      .lon_fdig    (lon_fdig),
      .hemi        (hemi),
      .date_acc    (date_acc),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign rsp_channel.valid = rsp_valid;
   assign rsp_channel.data  = rsp_data;

   // a line feed that ends a sentence reaches the output when the pipeline advances
   a_emit_reaches_output : assert property (@(posedge clock) disable iff (reset)
      emit ##1 advance |=> rsp_channel.valid)
      else $error("result missing after sentence end");

   // every new result comes from a sentence end through the conversion stage
   a_no_spurious_result : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_channel.valid) |-> $past(emit, 2))
      else $error("result without sentence end");

   // wrapped hour and minutes stay in range
   a_time_range : assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid |-> (rsp_channel.data.local_hour < 5'd24)
                         && (rsp_channel.data.minute_of_hour <= MINSEC_CAP))
      else $error("time field out of range");

endmodule

FILE: dv/nmea_rmc_position_extractor_tb.sv
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor_tb
// Self-checking bench for the RMC position extractor. Byte streams made of
// well-formed and broken sentences, header noise and random bytes go in on
// the request channel. A scoreboard tracks the parser state on every accepted
// transaction, predicts each result and checks it field by field as it comes
// out. The run steps through several hour offsets and idle/stall mixes and
// holds the result side off for a long stretch once.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_tb;
   import nrpe_pkg::*;

   localparam int          FRAC_DIGITS   = 4;
   localparam int          CLK_HALF      = 4;
   localparam int          RESET_CYCLES  = 11;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LONG_HOLD     = 400;
   localparam int          PHASE_RESULTS = 12;
   localparam int          MAX_REPORTS   = 10;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam char_type    CHAR_CR       = 8'h0D;

   class rmc_scoreboard;
      hour_type        hour_offset;
      hdr_state_type   hdr_state;
      bit              in_sentence;
      field_type       field_no;
      logic [3:0]      digit_pos;
      int unsigned     time_acc, lat_int, lat_frac, lon_int, lon_frac, date_acc;
      logic [1:0]      hemi;
      rsp_payload_type expected_q[$];
      int unsigned     bytes_taken, results_predicted, results_checked, mismatches;

      function new();
         hour_offset = HOUR_OFFSET_RESET;
         hdr_state = HDR_IDLE;
         in_sentence = 1'b0;
         clear_fields();
         bytes_taken = 0;
         results_predicted = 0;
         results_checked = 0;
         mismatches = 0;
      endfunction

      function void clear_fields();
         field_no = FIELD_NONE;
         digit_pos = '0;
         time_acc = 0;
         lat_int = 0;
         lat_frac = 0;
         lon_int = 0;
         lon_frac = 0;
         hemi = '0;
         date_acc = 0;
      endfunction

      function int unsigned limit(int unsigned v, int unsigned hi);
         return (v > hi) ? hi : v;
      endfunction

      function int unsigned pad_fraction(int unsigned acc);
         int unsigned have;
         have = digit_pos[3] ? int'(digit_pos[2:0]) : 0;
         while (have < FRAC_DIGITS) begin
            acc = acc * 10;
            have++;
         end
         return acc;
      endfunction

      function void close_field();
         if (field_no == FIELD_LAT) lat_frac = pad_fraction(lat_frac);
         else if (field_no == FIELD_LON) lon_frac = pad_fraction(lon_frac);
         digit_pos = '0;
      endfunction

      function void take_coord_digit(inout int unsigned ip, inout int unsigned fp,
                                     input int unsigned cap, input int unsigned d);
         if (digit_pos[3]) begin
            if (digit_pos[2:0] < FRAC_DIGITS) begin
               fp = fp * 10 + d;
               digit_pos++;
            end
         end else begin
            ip = limit(ip * 10 + d, cap);
            if (digit_pos[2:0] < 7) digit_pos++;
         end
      endfunction

      function void take_data_char(char_type c);
         bit          dig;
         int unsigned d;
         dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         d = int'(c) - int'(CHAR_ZERO);
         if (c == CHAR_COMMA) begin
            close_field();
            if (field_no < FIELD_LAST) field_no++;
            return;
         end
         if (c == CHAR_STAR) begin
            close_field();
            field_no = FIELD_LAST;
            return;
         end
         if (c == CHAR_DOT) begin
            if (!digit_pos[3]) digit_pos = 4'b1000;
            return;
         end
         case (field_no)
            FIELD_TIME: begin
               if (dig && !digit_pos[3] && digit_pos[2:0] < TIME_DIGITS) begin
                  time_acc = time_acc * 10 + d;
                  digit_pos++;
               end
            end
            FIELD_LAT: if (dig) take_coord_digit(lat_int, lat_frac, LAT_INT_CAP, d);
            FIELD_NS:  hemi[0] = (c == CHAR_S);
            FIELD_LON: if (dig) take_coord_digit(lon_int, lon_frac, LON_INT_CAP, d);
            FIELD_EW:  hemi[1] = (c == CHAR_W);
            FIELD_DATE: begin
               if (dig && !digit_pos[3] && digit_pos[2:0] < TIME_DIGITS) begin
                  date_acc = date_acc * 10 + d;
                  digit_pos++;
               end
            end
            default: ;
         endcase
      endfunction

      function rsp_payload_type position_fix();
         rsp_payload_type r;
         int unsigned     scale;
         scale = 10 ** FRAC_DIGITS;
         r.local_hour       = 5'((time_acc / 10000 + hour_offset) % HOURS_PER_DAY);
         r.minute_of_hour   = 6'(limit((time_acc / 100) % 100, MINSEC_CAP));
         r.second_of_minute = 6'(limit(time_acc % 100, MINSEC_CAP));
         r.lat_degrees      = 7'(limit(lat_int / 100, LAT_DEG_CAP));
         r.lat_minutes      = 6'(limit(lat_int % 100, MINSEC_CAP));
         r.lat_decisec      = 10'(limit(lat_frac * 600 / scale, DECISEC_CAP));
         r.lat_south        = hemi[0];
         r.lon_degrees      = 8'(limit(lon_int / 100, LON_DEG_CAP));
         r.lon_minutes      = 6'(limit(lon_int % 100, MINSEC_CAP));
         r.lon_decisec      = 10'(limit(lon_frac * 600 / scale, DECISEC_CAP));
         r.lon_west         = hemi[1];
         r.date_ddmmyy      = 19'(limit(date_acc, DATE_CAP));
         return r;
      endfunction

      function char_type next_header_char(hdr_state_type s);
         case (s)
            HDR_DOLLAR: return CHAR_G;
            HDR_G:      return CHAR_N;
            HDR_N:      return CHAR_R;
            HDR_R:      return CHAR_M;
            default:    return CHAR_C;
         endcase
      endfunction

      // called for every accepted request transaction
      function void note_byte(char_type c);
         bytes_taken++;
         if (c == CHAR_DOLLAR) begin
            clear_fields();
            in_sentence = 1'b0;
            hdr_state = HDR_DOLLAR;
            return;
         end
         if (in_sentence) begin
            if (c == CHAR_LF) begin
               close_field();
               expected_q.push_back(position_fix());
               results_predicted++;
               in_sentence = 1'b0;
               hdr_state = HDR_IDLE;
               clear_fields();
            end else begin
               take_data_char(c);
            end
            return;
         end
         if (hdr_state == HDR_C) begin
            hdr_state = HDR_IDLE;
            if (c == CHAR_COMMA) begin
               in_sentence = 1'b1;
               field_no = FIELD_TIME;
               digit_pos = '0;
            end
         end else if (hdr_state != HDR_IDLE && c == next_header_char(hdr_state)) begin
            hdr_state = hdr_state_type'(hdr_state + 1);
         end else begin
            hdr_state = HDR_IDLE;
         end
      endfunction

      function string fmt(rsp_payload_type r);
         return $sformatf({"hour=%0d min=%0d sec=%0d lat=%0d/%0d/%0d s=%0d ",
                           "lon=%0d/%0d/%0d w=%0d date=%0d"},
                          r.local_hour, r.minute_of_hour, r.second_of_minute,
                          r.lat_degrees, r.lat_minutes, r.lat_decisec, r.lat_south,
                          r.lon_degrees, r.lon_minutes, r.lon_decisec, r.lon_west,
                          r.date_ddmmyy);
      endfunction

      // called for every accepted result transaction
      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         string           bad;
         results_checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("[%0t] unexpected result %s", $time, fmt(got));
            return;
         end
         want = expected_q.pop_front();
         bad = "";
         if (got.local_hour !== want.local_hour) bad = {bad, " local_hour"};
         if (got.minute_of_hour !== want.minute_of_hour) bad = {bad, " minute_of_hour"};
         if (got.second_of_minute !== want.second_of_minute) bad = {bad, " second_of_minute"};
         if (got.lat_degrees !== want.lat_degrees) bad = {bad, " lat_degrees"};
         if (got.lat_minutes !== want.lat_minutes) bad = {bad, " lat_minutes"};
         if (got.lat_decisec !== want.lat_decisec) bad = {bad, " lat_decisec"};
         if (got.lat_south !== want.lat_south) bad = {bad, " lat_south"};
         if (got.lon_degrees !== want.lon_degrees) bad = {bad, " lon_degrees"};
         if (got.lon_minutes !== want.lon_minutes) bad = {bad, " lon_minutes"};
         if (got.lon_decisec !== want.lon_decisec) bad = {bad, " lon_decisec"};
         if (got.lon_west !== want.lon_west) bad = {bad, " lon_west"};
         if (got.date_ddmmyy !== want.date_ddmmyy) bad = {bad, " date_ddmmyy"};
         if (bad != "") begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("[%0t] result %0d mismatch in%s", $time, results_checked, bad);
               $display("   expected %s", fmt(want));
               $display("   actual   %s", fmt(got));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   hour_type    csr_wr_data;
   int unsigned sender_idle_pct;
   int unsigned rsp_stall_pct;
   bit          hold_req;
   int unsigned hold_left;
   int unsigned cycle_count;
   char_type    stream_q[$];
   rmc_scoreboard sb;

   nrpe_stream_if #(.payload_type(req_payload_type)) req_if ();
   nrpe_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   nmea_rmc_position_extractor #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_channel (req_if.sink),
      .rsp_channel (rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("nmea_rmc_position_extractor_tb: FAIL");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
   end

   function automatic string rand_digits(int n);
      string s = "";
      for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
      return s;
   endfunction

   function automatic void push_byte(char_type c);
      stream_q.push_back(c);
   endfunction

   function automatic void push_text(string s, int bad_at = -1);
      for (int i = 0; i < s.len(); i++) begin
         if (i == bad_at) stream_q.push_back(char_type'($urandom_range(255)));
         else stream_q.push_back(char_type'(s[i]));
      end
   endfunction

   function automatic void end_line();
      if ($urandom_range(1)) push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endfunction

   function automatic string coord_text(bit is_lon);
      string s;
      case ($urandom_range(5))
         0: s = "";
         1: begin
            s = rand_digits($urandom_range(1, 8));
            if ($urandom_range(1)) s = {s, ".", rand_digits($urandom_range(0, 7))};
         end
         default: begin
            if (is_lon)
               s = $sformatf("%03d%02d.%s", $urandom_range(180), $urandom_range(59),
                             rand_digits($urandom_range(0, 6)));
            else
               s = $sformatf("%02d%02d.%s", $urandom_range(90), $urandom_range(59),
                             rand_digits($urandom_range(0, 6)));
         end
      endcase
      if ($urandom_range(9) == 0) s = {s, ".7x"};
      return s;
   endfunction

   function automatic string rmc_sentence();
      string ns_opts[8] = '{"N", "S", "", "NS", "SN", "s", "SS", "W"};
      string ew_opts[8] = '{"E", "W", "", "EW", "WE", "w", "WW", "S"};
      string st_opts[3] = '{"A", "V", ""};
      string t, dt, tail;
      case ($urandom_range(4))
         0: t = "";
         1: t = rand_digits($urandom_range(1, 8));
         default: t = $sformatf("%02d%02d%02d.%s", $urandom_range(23), $urandom_range(59),
                                $urandom_range(59), rand_digits($urandom_range(0, 3)));
      endcase
      case ($urandom_range(4))
         0: dt = "";
         1: dt = rand_digits($urandom_range(1, 8));
         default: dt = $sformatf("%02d%02d%02d", $urandom_range(1, 31),
                                 $urandom_range(1, 12), $urandom_range(99));
      endcase
      case ($urandom_range(3))
         0: tail = $sformatf(",,,A*%02X", $urandom_range(255));
         1: tail = ",,";
         2: tail = ",,,,,,,,,,,,,,";
         default: tail = $sformatf(",,,A*%02X,S,9.1", $urandom_range(255));
      endcase
      return {"$GNRMC,", t, ",", st_opts[$urandom_range(2)], ",", coord_text(1'b0), ",",
              ns_opts[$urandom_range(7)], ",", coord_text(1'b1), ",",
              ew_opts[$urandom_range(7)], ",", rand_digits($urandom_range(0, 3)), ",",
              rand_digits($urandom_range(0, 3)), ",", dt, tail};
   endfunction

   // mostly well-formed sentences, plus broken ones and plain noise
   function automatic void add_chunk();
      string hdr_opts[4] = '{"$GPRMC", "$GNRMA", "$GNRMC$GN", "$GNRMCX"};
      string s;
      int    pick;
      s = rmc_sentence();
      pick = $urandom_range(99);
      if (pick < 70) begin
         push_text(s);
         end_line();
      end else if (pick < 78) begin
         push_text({hdr_opts[$urandom_range(3)], s.substr(6, s.len() - 1)});
         end_line();
      end else if (pick < 86) begin
         push_text(s.substr(0, $urandom_range(6, s.len() - 2)));
      end else if (pick < 92) begin
         push_text(s, $urandom_range(s.len() - 1));
         end_line();
      end else begin
         repeat ($urandom_range(1, 8)) push_byte(char_type'($urandom_range(255)));
      end
   endfunction

   function automatic void add_directed();
      push_text("$GNRMC,235959.99,A,9000.0000,S,18000.0000,W,0.0,0.0,311299,,,A*6C");
      push_byte(CHAR_LF);
      push_text("$GNRMC,000000.00,A,0000.0000,N,00000.0000,E,,,010100,,,A*00");
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
      // every accumulator overflowing
      push_text({"$GNRMC,999999999,V,9999999999.99999999,S,99999999999.9999999,W,,,",
                 "99999999,,,*00"});
      push_byte(CHAR_LF);
      push_text("$GNRMC,,,,,,,,,,,,,,,,,,,,*00");
      push_byte(CHAR_LF);
      push_text("$GNRMC,");
      push_byte(CHAR_LF);
      // short time, second dot, short fraction, last hemisphere char wins
      push_text("$GNRMC,1234,A,4807.0.38,NS,01131.5,EW,,,0101");
      push_byte(CHAR_LF);
      // stray characters in numbers, data after the asterisk
      push_text("$GNRMC,123519,A,48A07.03X8,N,011.31.5x,E,,,230394,,,A*6A,S,99");
      push_byte(CHAR_LF);
      // dollar in the middle drops the first sentence
      push_text("$GNRMC,120000,A,12$GNRMC,010203,A,3342.123456789,S,15112.1,E,,,150620");
      push_byte(CHAR_LF);
      push_text("$GPRMC,120000,A,1234.5,N,12345.6,E,,,010120*00");
      push_byte(CHAR_LF);
      push_text("$GNRMCA,1,2");
      push_byte(CHAR_LF);
      push_byte(CHAR_LF);
      push_text("GNRMC,");
      push_byte(CHAR_LF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("$GNRMC,12");
      push_byte(8'hFF);
      push_byte(8'h80);
      push_text("3456,A,0130.5,S,,,,,");
      push_byte(8'h7F);
      push_byte(CHAR_LF);
      push_text("$$GNRMC,010101,A,,,,,,,311300");
      push_byte(CHAR_LF);
   endfunction

   task automatic send_byte(input char_type c);
      while ($urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data.rx_byte <= c;
      do @(posedge clock); while (!req_if.ready);
      sb.note_byte(c);
   endtask

   task automatic send_stream();
      while (stream_q.size() != 0) send_byte(stream_q.pop_front());
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hour_offset(input hour_type v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.hour_offset = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned start;
      hour_type    offset;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      sender_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_req = 1'b0;
      hold_left = 0;
      cycle_count = 0;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_directed();
      send_stream();
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               sender_idle_pct = 0;
               rsp_stall_pct = 0;
               offset = 5'd23;
               hold_req = 1'b1;
            end
            1: begin
               sender_idle_pct = 50;
               rsp_stall_pct = 0;
               offset = 5'd0;
            end
            2: begin
               sender_idle_pct = 0;
               rsp_stall_pct = 50;
               offset = hour_type'($urandom_range(1, 22));
            end
            default: begin
               sender_idle_pct = 29;
               rsp_stall_pct = 29;
               offset = 5'd17;
            end
         endcase
         write_hour_offset(offset);
         start = sb.results_predicted;
         while (sb.results_predicted - start < PHASE_RESULTS) begin
            add_chunk();
            send_stream();
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d bytes, %0d results checked, offsets 2, 23, 0, mid-range, 17,",
               sb.bytes_taken, sb.results_checked);
      $display("with sender gaps, result stalls and one long result hold-off");
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("nmea_rmc_position_extractor_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches,
                  sb.expected_q.size());
         $display("nmea_rmc_position_extractor_tb: FAIL");
      end
      $finish;
   end

endmodule
